### design/kwlex_pkg.sv
// Shared types, character codes, token codes and lookup functions for the keyword lexer.
`timescale 1ns / 1ps
`default_nettype none

package kwlex_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LINE_BITS   = 24;
    localparam int LENGTH_BITS = 16;
    localparam int CODE_BITS   = 6;
    localparam int CHAR_BITS   = 8;

    // a word can only be a keyword while it is at most 7 characters long
    localparam int KW_MAX_CHARS = 7;
    localparam int WORD_BITS    = CHAR_BITS * KW_MAX_CHARS;

    localparam int FIELD_BITS = CODE_BITS + LINE_BITS + OFFSET_BITS + LENGTH_BITS;
    localparam int TDATA_BITS = ((FIELD_BITS + 7) / 8) * 8;

    // token codes
    localparam logic [CODE_BITS-1:0] TOK_STOP     = 6'd0;
    localparam logic [CODE_BITS-1:0] TOK_ERROR    = 6'd1;
    localparam logic [CODE_BITS-1:0] TOK_INTEGER  = 6'd2;
    localparam logic [CODE_BITS-1:0] TOK_IDENT    = 6'd3;
    localparam logic [CODE_BITS-1:0] TOK_PROGRAM  = 6'd4;
    localparam logic [CODE_BITS-1:0] TOK_VAR      = 6'd5;
    localparam logic [CODE_BITS-1:0] TOK_SKIP     = 6'd6;
    localparam logic [CODE_BITS-1:0] TOK_READ     = 6'd7;
    localparam logic [CODE_BITS-1:0] TOK_WRITE    = 6'd8;
    localparam logic [CODE_BITS-1:0] TOK_TRUE     = 6'd9;
    localparam logic [CODE_BITS-1:0] TOK_FALSE    = 6'd10;
    localparam logic [CODE_BITS-1:0] TOK_AND      = 6'd11;
    localparam logic [CODE_BITS-1:0] TOK_OR       = 6'd12;
    localparam logic [CODE_BITS-1:0] TOK_NOT      = 6'd13;
    localparam logic [CODE_BITS-1:0] TOK_IF       = 6'd14;
    localparam logic [CODE_BITS-1:0] TOK_THEN     = 6'd15;
    localparam logic [CODE_BITS-1:0] TOK_ELSE     = 6'd16;
    localparam logic [CODE_BITS-1:0] TOK_FI       = 6'd17;
    localparam logic [CODE_BITS-1:0] TOK_WHILE    = 6'd18;
    localparam logic [CODE_BITS-1:0] TOK_DO       = 6'd19;
    localparam logic [CODE_BITS-1:0] TOK_OD       = 6'd20;
    localparam logic [CODE_BITS-1:0] TOK_ASSIGN   = 6'd21;
    localparam logic [CODE_BITS-1:0] TOK_NEQ      = 6'd22;
    localparam logic [CODE_BITS-1:0] TOK_EQ       = 6'd23;
    localparam logic [CODE_BITS-1:0] TOK_GE       = 6'd24;
    localparam logic [CODE_BITS-1:0] TOK_LE       = 6'd25;
    localparam logic [CODE_BITS-1:0] TOK_COLON    = 6'd26;
    localparam logic [CODE_BITS-1:0] TOK_SEMI     = 6'd27;
    localparam logic [CODE_BITS-1:0] TOK_LT       = 6'd28;
    localparam logic [CODE_BITS-1:0] TOK_GT       = 6'd29;
    localparam logic [CODE_BITS-1:0] TOK_STAR     = 6'd30;
    localparam logic [CODE_BITS-1:0] TOK_SLASH    = 6'd31;
    localparam logic [CODE_BITS-1:0] TOK_PERCENT  = 6'd32;
    localparam logic [CODE_BITS-1:0] TOK_MINUS    = 6'd33;
    localparam logic [CODE_BITS-1:0] TOK_PLUS     = 6'd34;

    // characters
    localparam logic [CHAR_BITS-1:0] CH_COLON   = ":";
    localparam logic [CHAR_BITS-1:0] CH_SEMI    = ";";
    localparam logic [CHAR_BITS-1:0] CH_LT      = "<";
    localparam logic [CHAR_BITS-1:0] CH_GT      = ">";
    localparam logic [CHAR_BITS-1:0] CH_STAR    = "*";
    localparam logic [CHAR_BITS-1:0] CH_SLASH   = "/";
    localparam logic [CHAR_BITS-1:0] CH_PERCENT = "%";
    localparam logic [CHAR_BITS-1:0] CH_MINUS   = "-";
    localparam logic [CHAR_BITS-1:0] CH_PLUS    = "+";
    localparam logic [CHAR_BITS-1:0] CH_EQUAL   = "=";
    localparam logic [CHAR_BITS-1:0] CH_BANG    = "!";
    localparam logic [CHAR_BITS-1:0] CH_UNDER   = "_";
    localparam logic [CHAR_BITS-1:0] CH_SPACE   = " ";
    localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_BITS-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_BITS-1:0] CH_CR      = 8'd13;

    // keywords, right-justified and zero-filled
    localparam logic [WORD_BITS-1:0] KW_PROGRAM = "program";
    localparam logic [WORD_BITS-1:0] KW_VAR     = "var";
    localparam logic [WORD_BITS-1:0] KW_SKIP    = "skip";
    localparam logic [WORD_BITS-1:0] KW_READ    = "read";
    localparam logic [WORD_BITS-1:0] KW_WRITE   = "write";
    localparam logic [WORD_BITS-1:0] KW_TRUE    = "true";
    localparam logic [WORD_BITS-1:0] KW_FALSE   = "false";
    localparam logic [WORD_BITS-1:0] KW_AND     = "and";
    localparam logic [WORD_BITS-1:0] KW_OR      = "or";
    localparam logic [WORD_BITS-1:0] KW_NOT     = "not";
    localparam logic [WORD_BITS-1:0] KW_IF      = "if";
    localparam logic [WORD_BITS-1:0] KW_THEN    = "then";
    localparam logic [WORD_BITS-1:0] KW_ELSE    = "else";
    localparam logic [WORD_BITS-1:0] KW_FI      = "fi";
    localparam logic [WORD_BITS-1:0] KW_WHILE   = "while";
    localparam logic [WORD_BITS-1:0] KW_DO      = "do";
    localparam logic [WORD_BITS-1:0] KW_OD      = "od";

    typedef struct packed {
        logic [CODE_BITS-1:0]   code;
        logic [LINE_BITS-1:0]   line;
        logic [OFFSET_BITS-1:0] start;
        logic [LENGTH_BITS-1:0] length;
        logic                   last;
    } token_t;

    // up to two tokens produced by one accepted request
    typedef struct packed {
        logic [1:0] num;
        token_t     first;
        token_t     second;
    } tok_pair_t;

    function automatic logic [CODE_BITS-1:0] symbol_code(input logic [CHAR_BITS-1:0] b);
        logic [CODE_BITS-1:0] code;
        begin
            unique case (b)
                CH_COLON:   code = TOK_COLON;
                CH_SEMI:    code = TOK_SEMI;
                CH_LT:      code = TOK_LT;
                CH_GT:      code = TOK_GT;
                CH_STAR:    code = TOK_STAR;
                CH_SLASH:   code = TOK_SLASH;
                CH_PERCENT: code = TOK_PERCENT;
                CH_MINUS:   code = TOK_MINUS;
                CH_PLUS:    code = TOK_PLUS;
                default:    code = TOK_ERROR;
            endcase
            return code;
        end
    endfunction

    function automatic logic [CODE_BITS-1:0] keyword_code(input logic [WORD_BITS-1:0] w);
        logic [CODE_BITS-1:0] code;
        begin
            unique case (w)
                KW_PROGRAM: code = TOK_PROGRAM;
                KW_VAR:     code = TOK_VAR;
                KW_SKIP:    code = TOK_SKIP;
                KW_READ:    code = TOK_READ;
                KW_WRITE:   code = TOK_WRITE;
                KW_TRUE:    code = TOK_TRUE;
                KW_FALSE:   code = TOK_FALSE;
                KW_AND:     code = TOK_AND;
                KW_OR:      code = TOK_OR;
                KW_NOT:     code = TOK_NOT;
                KW_IF:      code = TOK_IF;
                KW_THEN:    code = TOK_THEN;
                KW_ELSE:    code = TOK_ELSE;
                KW_FI:      code = TOK_FI;
                KW_WHILE:   code = TOK_WHILE;
                KW_DO:      code = TOK_DO;
                KW_OD:      code = TOK_OD;
                default:    code = TOK_IDENT;
            endcase
            return code;
        end
    endfunction

    // second character '=' completes one of := != == >= <=
    function automatic logic [CODE_BITS-1:0] pair_code(input logic [CHAR_BITS-1:0] head);
        logic [CODE_BITS-1:0] code;
        begin
            unique case (head)
                CH_COLON: code = TOK_ASSIGN;
                CH_BANG:  code = TOK_NEQ;
                CH_EQUAL: code = TOK_EQ;
                CH_GT:    code = TOK_GE;
                default:  code = TOK_LE;
            endcase
            return code;
        end
    endfunction

endpackage

`default_nettype wire

### design/kwlex_core.sv
// Scanner state and per-character token generation for the keyword lexer.
`timescale 1ns / 1ps
`default_nettype none

module kwlex_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_fire,
    input  wire logic                            in_end,
    input  wire logic [kwlex_pkg::CHAR_BITS-1:0] in_char,
    output kwlex_pkg::tok_pair_t                 toks
);
    import kwlex_pkg::*;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_NUMBER = 2'd1;
    localparam logic [1:0] MODE_WORD   = 2'd2;
    localparam logic [1:0] MODE_SYMBOL = 2'd3;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_KW   = LENGTH_BITS'(KW_MAX_CHARS);

    logic [1:0]             mode_reg,   mode_next;
    logic [CHAR_BITS-1:0]   pend_reg,   pend_next;
    logic [WORD_BITS-1:0]   prefix_reg, prefix_next;
    logic [LENGTH_BITS-1:0] len_reg,    len_next;
    logic [OFFSET_BITS-1:0] start_reg,  start_next;
    logic [OFFSET_BITS-1:0] pos_reg,    pos_next;
    logic [LINE_BITS-1:0]   line_reg,   line_next;

    logic   is_digit, is_letter, is_space, is_word, is_pair_head;
    logic   flush_v, new_v;
    token_t flush_tok, new_tok;

    always_comb begin
        is_digit     = (in_char >= "0") && (in_char <= "9");
        is_letter    = ((in_char >= "a") && (in_char <= "z")) ||
                       ((in_char >= "A") && (in_char <= "Z"));
        is_space     = (in_char == CH_SPACE) || ((in_char >= CH_TAB) && (in_char <= CH_CR));
        is_word      = is_letter || is_digit || (in_char == CH_UNDER);
        is_pair_head = (in_char == CH_COLON) || (in_char == CH_BANG) ||
                       (in_char == CH_EQUAL) || (in_char == CH_LT) || (in_char == CH_GT);
    end

    // token that a pending run would give if it ended now
    always_comb begin
        flush_tok.line  = line_reg;
        flush_tok.start = start_reg;
        flush_tok.last  = 1'b0;
        case (mode_reg)
            MODE_NUMBER: begin
                flush_tok.code   = TOK_INTEGER;
                flush_tok.length = len_reg;
            end
            MODE_WORD: begin
                flush_tok.code   = (len_reg > LEN_KW) ? TOK_IDENT : keyword_code(prefix_reg);
                flush_tok.length = len_reg;
            end
            default: begin
                flush_tok.code   = symbol_code(pend_reg);
                flush_tok.length = LENGTH_BITS'(1);
            end
        endcase
    end

    always_comb begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        prefix_next = prefix_reg;
        len_next    = len_reg;
        start_next  = start_reg;
        pos_next    = pos_reg + OFFSET_BITS'(1);
        line_next   = line_reg;
        flush_v     = 1'b0;
        new_v       = 1'b0;
        new_tok.code   = symbol_code(in_char);
        new_tok.line   = line_reg;
        new_tok.start  = pos_reg;
        new_tok.length = LENGTH_BITS'(1);
        new_tok.last   = 1'b0;

        if (in_end) begin
            flush_v        = (mode_reg != MODE_IDLE);
            new_v          = 1'b1;
            new_tok.code   = TOK_STOP;
            new_tok.length = '0;
            mode_next      = MODE_IDLE;
            pend_next      = '0;
            prefix_next    = '0;
            len_next       = '0;
            start_next     = '0;
            pos_next       = '0;
            line_next      = LINE_ONE;
        end else if ((mode_reg == MODE_NUMBER) && is_digit) begin
            if (len_reg != LEN_MAX) begin
                len_next = len_reg + LENGTH_BITS'(1);
            end
        end else if ((mode_reg == MODE_WORD) && is_word) begin
            // bytes past the seventh fall off the top; such a word is an identifier anyway
            prefix_next = {prefix_reg[WORD_BITS-CHAR_BITS-1:0], in_char};
            if (len_reg != LEN_MAX) begin
                len_next = len_reg + LENGTH_BITS'(1);
            end
        end else if ((mode_reg == MODE_SYMBOL) && (in_char == CH_EQUAL)) begin
            new_v          = 1'b1;
            new_tok.code   = pair_code(pend_reg);
            new_tok.start  = start_reg;
            new_tok.length = LENGTH_BITS'(2);
            mode_next      = MODE_IDLE;
        end else begin
            flush_v   = (mode_reg != MODE_IDLE);
            mode_next = MODE_IDLE;
            if (is_space) begin
                // line bump lands after the flushed token took the old line
                if ((in_char == CH_NEWLINE) && (line_reg != LINE_MAX)) begin
                    line_next = line_reg + LINE_BITS'(1);
                end
            end else if (is_digit) begin
                mode_next  = MODE_NUMBER;
                start_next = pos_reg;
                len_next   = LENGTH_BITS'(1);
            end else if (is_letter || (in_char == CH_UNDER)) begin
                mode_next   = MODE_WORD;
                start_next  = pos_reg;
                len_next    = LENGTH_BITS'(1);
                prefix_next = WORD_BITS'(in_char);
            end else if (is_pair_head) begin
                mode_next  = MODE_SYMBOL;
                start_next = pos_reg;
                pend_next  = in_char;
            end else begin
                new_v = 1'b1;
            end
        end
    end

    // order the tokens and mark the final one of this request
    always_comb begin
        toks.first       = flush_v ? flush_tok : new_tok;
        toks.second      = new_tok;
        toks.first.last  = !(flush_v && new_v);
        toks.second.last = 1'b1;
        if (!in_fire) begin
            toks.num = 2'd0;
        end else begin
            toks.num = 2'(flush_v) + 2'(new_v);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            pos_reg  <= '0;
            line_reg <= LINE_ONE;
        end else if (in_fire) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            line_reg <= line_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            pend_reg   <= pend_next;
            prefix_reg <= prefix_next;
            len_reg    <= len_next;
            start_reg  <= start_next;
        end
    end

`ifndef SYNTHESIS
    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg != '0)
        else $error("line counter reached zero");

    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_end |=> (mode_reg == MODE_IDLE) && (pos_reg == '0) &&
                              (line_reg == LINE_ONE))
        else $error("scanner state not restored after end of input");

    a_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_end |-> (toks.num != 2'd0) &&
                              ((toks.num == 2'd1) ? (toks.first.code == TOK_STOP)
                                                  : (toks.second.code == TOK_STOP)))
        else $error("end of input without a stop token");

    a_two_no_space: assert property (@(posedge aclk) disable iff (!aresetn)
        toks.num == 2'd2 |-> !toks.first.last)
        else $error("first of two tokens marked final");
`endif

endmodule

`default_nettype wire

### design/kwlex_fifo.sv
// Four-entry token queue: takes up to two tokens a cycle, hands out one.
`timescale 1ns / 1ps
`default_nettype none

module kwlex_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire kwlex_pkg::tok_pair_t push,
    output logic                      room,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output kwlex_pkg::token_t         out_tok
);
    import kwlex_pkg::*;

    localparam int DEPTH    = 4;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [CNT_BITS-1:0] ROOM_LIMIT = CNT_BITS'(DEPTH - 2);

    token_t                mem [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg,  count_next;
    logic [PTR_BITS-1:0]   wr_ptr_plus1;
    logic                  pop;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_BITS'(1);
    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_tok      = mem[rd_ptr_reg];
    // leave space for the worst case of two tokens from the next request
    assign room         = (count_reg <= ROOM_LIMIT);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.num);
        rd_ptr_next = pop ? (rd_ptr_reg + PTR_BITS'(1)) : rd_ptr_reg;
        count_next  = count_reg + CNT_BITS'(push.num) - CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2) begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("token queue overflow");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        PTR_BITS'(wr_ptr_reg - rd_ptr_reg) == PTR_BITS'(count_reg))
        else $error("queue pointers disagree with fill count");

    a_valid_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid)
        else $error("queued token dropped while stalled");
`endif

endmodule

`default_nettype wire

### design/keyword_lexer.sv
// Top level of the keyword lexer: stream ports around the scanner and the token queue.
//
// Usage: source bytes enter on the s_ channel one request at a time, s_tdata holding the
// byte and s_tuser flagging end of input (byte then ignored). Tokens leave on the m_
// channel: code, line, start offset and length in m_tdata; m_tlast marks the final token
// caused by one input request. A byte may cause no token (whitespace, a growing run),
// one token, or two (a flushed run plus a token of its own); end of input gives an
// optional flush token followed by a stop token, and then the scanner is back in its
// reset state for the next stream.
// Timing: a token caused by a byte is written into the token queue as that byte is accepted,
// so it is registered before it reaches m_. Throughput: one byte per cycle while the output
// keeps up; the single-token-per-cycle output port is the limit, so a request that yields two
// tokens uses the output port for each of them. s_tready is high while the four-entry token
// queue has room for two tokens, so a stalled receiver backs up into the input after three or four queued tokens.
// Reset (aresetn low, synchronous) empties the queue, sets line 1 and offset 0.
`timescale 1ns / 1ps
`default_nettype none

module keyword_lexer (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] char_byte
    input  wire logic                             s_tuser,   // [0] action
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [5:0] token_code, [29:6] line_number, [61:30] start_offset, [77:62] token_length
    output logic [kwlex_pkg::TDATA_BITS-1:0]      m_tdata,
    output logic                                  m_tlast
);
    import kwlex_pkg::*;

    tok_pair_t toks;
    token_t    head_tok;
    logic      room;
    logic      in_fire;

    assign s_tready = room;
    assign in_fire  = s_tvalid && room;

    kwlex_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_end  (s_tuser),
        .in_char (s_tdata[CHAR_BITS-1:0]),
        .toks    (toks)
    );

    kwlex_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (toks),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (head_tok)
    );

    assign m_tdata = TDATA_BITS'({head_tok.length, head_tok.start, head_tok.line,
                                  head_tok.code});
    assign m_tlast = head_tok.last;

`ifndef SYNTHESIS
    a_no_token_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_fire |-> toks.num == 2'd0)
        else $error("token produced without an input request");

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output token changed while stalled");

    a_m_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !$isunknown({m_tdata, m_tlast}))
        else $error("output token has unknown bits");
`endif

endmodule

`default_nettype wire

### sim/tb_keyword_lexer.sv
// Self-checking stream testbench for the keyword lexer, with its own token predictor.
`timescale 1ns / 1ps

module tb_keyword_lexer;
    import kwlex_pkg::*;

    localparam int IDLE_LIMIT = 2000;   // cycles with no transfer on either side
    localparam int LONG_HOLD  = 300;    // receiver hold-off for the backpressure test
    localparam int MAX_REPORTS = 10;
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_WORD, SCAN_SYMBOL} scan_mode_e;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'd0;   // [7:0] char_byte
    logic                  s_tuser  = 1'b0;   // [0] action
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [5:0] token_code, [29:6] line_number, [61:30] start_offset, [77:62] token_length
    logic [TDATA_BITS-1:0] m_tdata;
    logic                  m_tlast;

    keyword_lexer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial forever #1 aclk = ~aclk;

    string keyword_text[17] = '{"program", "var", "skip", "read", "write", "true", "false",
                                "and", "or", "not", "if", "then", "else", "fi", "while",
                                "do", "od"};
    string pair_text[5] = '{":=", "!=", "==", ">=", "<="};
    logic [7:0] symbol_chars[9] = '{CH_COLON, CH_SEMI, CH_LT, CH_GT, CH_STAR, CH_SLASH,
                                    CH_PERCENT, CH_MINUS, CH_PLUS};

    token_t tokens_due[$];
    token_t step_tokens[$];
    int     mismatches = 0;
    int     bytes_sent = 0;
    int     stuck_cycles = 0;
    int     rx_hold = 0;
    bit     calm = 1'b0;
    bit     long_hold_pending = 1'b0;

    // scanner state as predicted
    scan_mode_e             lx_mode;
    logic [7:0]             lx_head;
    logic [63:0]            lx_word;
    logic [LENGTH_BITS-1:0] lx_len;
    logic [OFFSET_BITS-1:0] lx_start;
    logic [OFFSET_BITS-1:0] lx_pos;
    logic [LINE_BITS-1:0]   lx_line;

    function automatic bit is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic [CODE_BITS-1:0] symbol_kind(input logic [7:0] b);
        logic [CODE_BITS-1:0] code;
        code = TOK_ERROR;
        for (int i = 0; i < 9; i++)
            if (symbol_chars[i] == b) code = TOK_COLON + CODE_BITS'(i);
        return code;
    endfunction

    function automatic logic [CODE_BITS-1:0] word_kind();
        logic [CODE_BITS-1:0] code;
        logic [63:0]          kw;
        code = TOK_IDENT;
        if (lx_len <= LENGTH_BITS'(KW_MAX_CHARS)) begin
            for (int i = 0; i < 17; i++) begin
                kw = '0;
                for (int j = 0; j < keyword_text[i].len(); j++)
                    kw = {kw[55:0], keyword_text[i][j]};
                if (kw == lx_word) code = TOK_PROGRAM + CODE_BITS'(i);
            end
        end
        return code;
    endfunction

    function automatic logic [CODE_BITS-1:0] pair_kind(input logic [7:0] head);
        case (head)
            CH_COLON: return TOK_ASSIGN;
            CH_BANG:  return TOK_NEQ;
            CH_EQUAL: return TOK_EQ;
            CH_GT:    return TOK_GE;
            default:  return TOK_LE;
        endcase
    endfunction

    task automatic predict_reset();
        lx_mode  = SCAN_IDLE;
        lx_head  = '0;
        lx_word  = '0;
        lx_len   = '0;
        lx_start = '0;
        lx_pos   = '0;
        lx_line  = LINE_BITS'(1);
    endtask

    task automatic emit_token(input logic [CODE_BITS-1:0] code,
                              input logic [OFFSET_BITS-1:0] start,
                              input logic [LENGTH_BITS-1:0] len);
        token_t t;
        t.code   = code;
        t.line   = lx_line;
        t.start  = start;
        t.length = len;
        t.last   = 1'b0;
        step_tokens.push_back(t);
    endtask

    task automatic flush_run();
        case (lx_mode)
            SCAN_NUMBER: emit_token(TOK_INTEGER, lx_start, lx_len);
            SCAN_WORD:   emit_token(word_kind(), lx_start, lx_len);
            SCAN_SYMBOL: emit_token(symbol_kind(lx_head), lx_start, LENGTH_BITS'(1));
            default: ;
        endcase
        lx_mode = SCAN_IDLE;
    endtask

    // tokens caused by one accepted request, appended to tokens_due
    task automatic scan_byte(input logic act, input logic [7:0] ch);
        step_tokens.delete();
        if (act == ACT_END) begin
            flush_run();
            emit_token(TOK_STOP, lx_pos, LENGTH_BITS'(0));
            predict_reset();
        end else begin
            if (lx_mode == SCAN_NUMBER && is_digit(ch)) begin
                if (lx_len < LEN_MAX) lx_len++;
            end else if (lx_mode == SCAN_WORD && (is_letter(ch) || is_digit(ch)
                                                  || ch == CH_UNDER)) begin
                if (lx_len < LENGTH_BITS'(8)) lx_word = {lx_word[55:0], ch};
                if (lx_len < LEN_MAX) lx_len++;
            end else if (lx_mode == SCAN_SYMBOL && ch == CH_EQUAL) begin
                emit_token(pair_kind(lx_head), lx_start, LENGTH_BITS'(2));
                lx_mode = SCAN_IDLE;
            end else begin
                flush_run();
                if (is_blank(ch)) begin
                    if (ch == CH_NEWLINE && lx_line < LINE_MAX) lx_line++;
                end else if (is_digit(ch)) begin
                    lx_mode  = SCAN_NUMBER;
                    lx_start = lx_pos;
                    lx_len   = LENGTH_BITS'(1);
                end else if (is_letter(ch) || ch == CH_UNDER) begin
                    lx_mode  = SCAN_WORD;
                    lx_start = lx_pos;
                    lx_len   = LENGTH_BITS'(1);
                    lx_word  = {56'd0, ch};
                end else if (ch == CH_COLON || ch == CH_BANG || ch == CH_EQUAL
                             || ch == CH_LT || ch == CH_GT) begin
                    lx_mode  = SCAN_SYMBOL;
                    lx_start = lx_pos;
                    lx_head  = ch;
                end else begin
                    emit_token(symbol_kind(ch), lx_pos, LENGTH_BITS'(1));
                end
            end
            lx_pos++;
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
    endtask

    task automatic send_byte(input logic act, input logic [7:0] ch);
        int gap;
        if (!calm && $urandom_range(0, 6) == 0) begin
            gap = int'($urandom_range(1, 9));
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        scan_byte(act, ch);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(ACT_CHAR, s[i]);
    endtask

    function automatic logic [7:0] word_char(input bit first);
        int r;
        r = int'($urandom_range(0, first ? 52 : 62));
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + (r - 26));
        if (r == 52) return CH_UNDER;
        return 8'("0" + (r - 53));
    endfunction

    // operators, lone '!' and '=', non-ASCII bytes, newline flush, pending symbol at end
    task automatic test_mixed_tokens();
        send_text("if x>=9\n");
        send_text("_!=!;");
        send_byte(ACT_CHAR, 8'hFF);
        send_byte(ACT_CHAR, 8'h80);
        send_byte(ACT_CHAR, 8'h00);
        send_text("==<>==");
        send_byte(ACT_END, 8'hFF);
    endtask

    task automatic test_keyword_table();
        foreach (keyword_text[i]) begin
            send_text(keyword_text[i]);
            send_byte(ACT_CHAR, CH_SPACE);
        end
        // eight characters is too long for a keyword
        send_text("programs\twhile_\r\n");
        send_byte(ACT_END, 8'h00);
    endtask

    // long number and long word runs, far past the keyword width
    task automatic test_long_runs();
        for (int i = 0; i < 30; i++) send_byte(ACT_CHAR, "5");
        send_byte(ACT_CHAR, CH_SEMI);
        send_byte(ACT_CHAR, "w");
        for (int i = 0; i < 30; i++) send_byte(ACT_CHAR, "a");
        send_byte(ACT_END, 8'h55);
    endtask

    task automatic test_random_source(input int quota);
        int first_count;
        int n;
        first_count = bytes_sent;
        while (bytes_sent - first_count < quota) begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_text(keyword_text[$urandom_range(0, 16)]);
                3: begin
                    n = int'($urandom_range(1, 10));
                    for (int i = 0; i < n; i++) send_byte(ACT_CHAR, word_char(i == 0));
                end
                4: begin
                    n = int'($urandom_range(1, 6));
                    for (int i = 0; i < n; i++)
                        send_byte(ACT_CHAR, 8'("0" + $urandom_range(0, 9)));
                end
                5: send_text(pair_text[$urandom_range(0, 4)]);
                6: send_byte(ACT_CHAR, symbol_chars[$urandom_range(0, 8)]);
                7: send_byte(ACT_CHAR, 8'($urandom_range(0, 255)));
                8: send_byte(ACT_CHAR, $urandom_range(0, 1) ? CH_BANG : CH_EQUAL);
                default: begin
                    if ($urandom_range(0, 2) == 0)
                        send_byte(ACT_END, 8'($urandom_range(0, 255)));
                    else
                        send_byte(ACT_CHAR, CH_NEWLINE);
                end
            endcase
            case ($urandom_range(0, 5))
                0, 1: send_byte(ACT_CHAR, CH_SPACE);
                2:    send_byte(ACT_CHAR, CH_NEWLINE);
                3:    send_byte(ACT_CHAR, 8'($urandom_range(9, 13)));
                default: ;   // adjacent tokens
            endcase
        end
    endtask

    // receiver stops for a long stretch while single-symbol requests keep coming
    task automatic test_backpressure();
        long_hold_pending = 1'b1;
        for (int i = 0; i < 40; i++) send_byte(ACT_CHAR, symbol_chars[i % 9]);
        send_text("x:=1");
    endtask

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rx_hold  <= LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            rx_hold  <= int'($urandom_range(0, 8));
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : token_check
        token_t got;
        token_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles = 0;
            else stuck_cycles++;
            if (stuck_cycles >= IDLE_LIMIT) begin
                $display("keyword_lexer regression: fail");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got.code   = m_tdata[5:0];
                got.line   = m_tdata[29:6];
                got.start  = m_tdata[61:30];
                got.length = m_tdata[77:62];
                got.last   = m_tlast;
                if (tokens_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected token: code %0d line %0d start %0d len %0d last %0b",
                                 got.code, got.line, got.start, got.length, got.last);
                end else begin
                    want = tokens_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"token mismatch: expected code %0d line %0d start %0d ",
                                      "len %0d last %0b, got code %0d line %0d start %0d ",
                                      "len %0d last %0b"},
                                     want.code, want.line, want.start, want.length, want.last,
                                     got.code, got.line, got.start, got.length, got.last);
                    end
                end
            end
        end
    end

    initial begin
        predict_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_mixed_tokens();
        test_keyword_table();
        test_long_runs();
        test_random_source(550);
        test_backpressure();
        test_random_source(500);
        calm = 1'b1;
        test_random_source(270);
        send_byte(ACT_END, 8'h00);
        s_tvalid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && tokens_due.size() == 0)
            $display("keyword_lexer regression: pass");
        else
            $display("keyword_lexer regression: fail");
        $finish;
    end

endmodule

### keyword_lexer.f
design/kwlex_pkg.sv
design/kwlex_core.sv
design/kwlex_fifo.sv
design/keyword_lexer.sv
sim/tb_keyword_lexer.sv
